// ----- rtl/core/assert_macros.svh -----
// Assertion helpers, clocked on aclk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/kpt_pkg.sv -----
package kpt_pkg;

    localparam int SERIAL_W = 28;
    localparam int IN_SERIAL_W = 32;
    localparam int COUNTER_W = 16;
    localparam int KEY_W = 64;
    localparam int OP_W = 3;
    localparam int STATUS_W = 3;
    localparam int INDEX_IN_W = 8;
    localparam int ENTRY_INDEX_W = 7;
    localparam int OCC_W = 8;

    localparam logic [OP_W-1:0] OP_FIND    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_CNT = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_KEY = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ    = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

endpackage

// ----- rtl/core/kpt_ram.sv -----
module kpt_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/keyed_pairing_table.sv -----
// Keyed pairing table: a store of paired transmitter entries (serial, valid and
// factory marks, sync counter, device key), one operation per input item.
// Input channel s_*: op, serial (low 28 bits used), factory mark, index,
// counter and key. Result channel m_*: status, entry index, read-back fields
// and occupancy; exactly one result per input item.
// Path from input accept to result: find, add and remove scan the serial store
// (S_SCAN) and then finish in S_EXEC; read passes through S_READ, then S_EXEC;
// all other operations go straight to S_EXEC. The next item can be accepted at
// the edge at which the result can first be taken. The serial store has one read
// port and is scanned one entry per cycle for find, add and remove; the next item
// is taken once the current one has placed its result in the output register,
// so a held result does not block intake, but a stalled receiver holds the next
// item in its final cycle.
// Reset: the table is empty, and every counter, key and serial reads as zero.
// Counters and keys reset through per-entry written bits; no clearing pass.
`include "assert_macros.svh"

module keyed_pairing_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [31:0] s_serial_in,
    input  logic        s_factory_in,
    input  logic [7:0]  s_index_in,
    input  logic [15:0] s_counter_in,
    input  logic [63:0] s_key_in,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [6:0]  m_entry_index,
    output logic [27:0] m_rd_serial,
    output logic [15:0] m_rd_counter,
    output logic [63:0] m_rd_key,
    output logic        m_rd_valid,
    output logic        m_rd_factory,
    output logic [7:0]  m_occupancy
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_EXEC = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [kpt_pkg::OP_W-1:0]       op_reg, op_next;
    logic [kpt_pkg::SERIAL_W-1:0]   serial_reg, serial_next;
    logic                           factory_reg, factory_next;
    logic [kpt_pkg::INDEX_IN_W-1:0] index_reg, index_next;
    logic [kpt_pkg::COUNTER_W-1:0]  counter_reg, counter_next;
    logic [kpt_pkg::KEY_W-1:0]      key_reg, key_next;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0] factory_vec_reg, factory_vec_next;
    logic [TABLE_ENTRIES-1:0] cnt_wr_reg, cnt_wr_next;
    logic [TABLE_ENTRIES-1:0] key_wr_reg, key_wr_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_reg, issue_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic                                m_valid_reg, m_valid_next;
    logic [kpt_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [kpt_pkg::ENTRY_INDEX_W-1:0]   eidx_reg, eidx_next;
    logic [kpt_pkg::SERIAL_W-1:0]        rd_serial_reg, rd_serial_next;
    logic [kpt_pkg::COUNTER_W-1:0]       rd_counter_reg, rd_counter_next;
    logic [kpt_pkg::KEY_W-1:0]           rd_key_reg, rd_key_next;
    logic                                rd_valid_reg, rd_valid_next;
    logic                                rd_factory_reg, rd_factory_next;

    logic [IDX_W-1:0]              cell_idx;
    logic                          in_range;
    logic                          exec_go;
    logic                          accept;
    logic                          match;

    logic                          ser_we;
    logic [IDX_W-1:0]              ser_raddr;
    logic [kpt_pkg::SERIAL_W-1:0]  ser_q;
    logic                          cnt_we;
    logic [kpt_pkg::COUNTER_W-1:0] cnt_q;
    logic                          key_we;
    logic [kpt_pkg::KEY_W-1:0]     key_q;

    assign cell_idx  = index_reg[IDX_W-1:0];
    assign in_range  = index_reg < kpt_pkg::INDEX_IN_W'(TABLE_ENTRIES);
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign exec_go   = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign ser_raddr = (state_reg == S_SCAN) ? scan_idx_reg : cell_idx;
    assign match     = valid_reg[cmp_idx_reg] && (ser_q == serial_reg);

    assign ser_we = exec_go && (op_reg == kpt_pkg::OP_ADD) && !hit_reg && free_reg;
    assign cnt_we = exec_go && (op_reg == kpt_pkg::OP_SET_CNT) && in_range;
    assign key_we = exec_go && (op_reg == kpt_pkg::OP_SET_KEY) && in_range;

    kpt_ram #(
        .WIDTH(kpt_pkg::SERIAL_W),
        .DEPTH(TABLE_ENTRIES),
        .AW   (IDX_W)
    ) u_serial_ram (
        .aclk (aclk),
        .we   (ser_we),
        .waddr(free_idx_reg),
        .wdata(serial_reg),
        .raddr(ser_raddr),
        .rdata(ser_q)
    );

    kpt_ram #(
        .WIDTH(kpt_pkg::COUNTER_W),
        .DEPTH(TABLE_ENTRIES),
        .AW   (IDX_W)
    ) u_counter_ram (
        .aclk (aclk),
        .we   (cnt_we),
        .waddr(cell_idx),
        .wdata(counter_reg),
        .raddr(cell_idx),
        .rdata(cnt_q)
    );

    kpt_ram #(
        .WIDTH(kpt_pkg::KEY_W),
        .DEPTH(TABLE_ENTRIES),
        .AW   (IDX_W)
    ) u_key_ram (
        .aclk (aclk),
        .we   (key_we),
        .waddr(cell_idx),
        .wdata(key_reg),
        .raddr(cell_idx),
        .rdata(key_q)
    );

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        serial_next      = serial_reg;
        factory_next     = factory_reg;
        index_next       = index_reg;
        counter_next     = counter_reg;
        key_next         = key_reg;
        valid_next       = valid_reg;
        factory_vec_next = factory_vec_reg;
        cnt_wr_next      = cnt_wr_reg;
        key_wr_next      = key_wr_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        issue_next       = issue_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_vld_next     = 1'b0;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        status_next      = status_reg;
        eidx_next        = eidx_reg;
        rd_serial_next   = rd_serial_reg;
        rd_counter_next  = rd_counter_reg;
        rd_key_next      = rd_key_reg;
        rd_valid_next    = rd_valid_reg;
        rd_factory_next  = rd_factory_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next       = s_op;
                    serial_next   = s_serial_in[kpt_pkg::SERIAL_W-1:0];
                    factory_next  = s_factory_in;
                    index_next    = s_index_in;
                    counter_next  = s_counter_in;
                    key_next      = s_key_in;
                    scan_idx_next = '0;
                    issue_next    = 1'b1;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    unique case (s_op) inside
                        kpt_pkg::OP_FIND, kpt_pkg::OP_ADD, kpt_pkg::OP_REMOVE: begin
                            state_next = S_SCAN;
                        end
                        kpt_pkg::OP_READ: begin
                            state_next = S_READ;
                        end
                        default: begin
                            state_next = S_EXEC;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (issue_reg) begin
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
                cmp_vld_next = issue_reg;
                cmp_idx_next = scan_idx_reg;
                if (cmp_vld_reg) begin
                    if (match && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX) begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next      = S_IDLE;
                    m_valid_next    = 1'b1;
                    status_next     = kpt_pkg::ST_OK;
                    eidx_next       = '0;
                    rd_serial_next  = '0;
                    rd_counter_next = '0;
                    rd_key_next     = '0;
                    rd_valid_next   = 1'b0;
                    rd_factory_next = 1'b0;
                    unique case (op_reg)
                        kpt_pkg::OP_FIND: begin
                            if (hit_reg) begin
                                eidx_next = kpt_pkg::ENTRY_INDEX_W'(hit_idx_reg);
                            end else begin
                                status_next = kpt_pkg::ST_NOT_FOUND;
                            end
                        end
                        kpt_pkg::OP_ADD: begin
                            if (hit_reg) begin
                                status_next = kpt_pkg::ST_PRESENT;
                                eidx_next   = kpt_pkg::ENTRY_INDEX_W'(hit_idx_reg);
                            end else if (free_reg) begin
                                valid_next[free_idx_reg]       = 1'b1;
                                factory_vec_next[free_idx_reg] = factory_reg;
                                cnt_wr_next[free_idx_reg]      = 1'b0;
                                count_next = count_reg + CNT_W'(1);
                                eidx_next  = kpt_pkg::ENTRY_INDEX_W'(free_idx_reg);
                            end else begin
                                status_next = kpt_pkg::ST_FULL;
                            end
                        end
                        kpt_pkg::OP_REMOVE: begin
                            if (hit_reg) begin
                                valid_next[hit_idx_reg]       = 1'b0;
                                factory_vec_next[hit_idx_reg] = 1'b0;
                                count_next = count_reg - CNT_W'(1);
                                eidx_next  = kpt_pkg::ENTRY_INDEX_W'(hit_idx_reg);
                            end else begin
                                status_next = kpt_pkg::ST_NOT_FOUND;
                            end
                        end
                        kpt_pkg::OP_SET_CNT: begin
                            if (in_range) begin
                                cnt_wr_next[cell_idx] = 1'b1;
                                eidx_next = kpt_pkg::ENTRY_INDEX_W'(index_reg);
                            end else begin
                                status_next = kpt_pkg::ST_BAD_INDEX;
                            end
                        end
                        kpt_pkg::OP_SET_KEY: begin
                            if (in_range) begin
                                key_wr_next[cell_idx] = 1'b1;
                                eidx_next = kpt_pkg::ENTRY_INDEX_W'(index_reg);
                            end else begin
                                status_next = kpt_pkg::ST_BAD_INDEX;
                            end
                        end
                        kpt_pkg::OP_CLEAR: begin
                            valid_next       = '0;
                            factory_vec_next = '0;
                            count_next       = '0;
                        end
                        kpt_pkg::OP_READ: begin
                            if (in_range) begin
                                eidx_next       = kpt_pkg::ENTRY_INDEX_W'(index_reg);
                                rd_valid_next   = valid_reg[cell_idx];
                                rd_factory_next = factory_vec_reg[cell_idx];
                                rd_serial_next  = valid_reg[cell_idx] ? ser_q : '0;
                                rd_counter_next = cnt_wr_reg[cell_idx] ? cnt_q : '0;
                                rd_key_next     = key_wr_reg[cell_idx] ? key_q : '0;
                            end else begin
                                status_next = kpt_pkg::ST_BAD_INDEX;
                            end
                        end
                        default: begin
                            status_next = kpt_pkg::ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            factory_vec_reg <= '0;
            cnt_wr_reg      <= '0;
            key_wr_reg      <= '0;
            count_reg       <= '0;
            issue_reg       <= 1'b0;
            cmp_vld_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            free_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            factory_vec_reg <= factory_vec_next;
            cnt_wr_reg      <= cnt_wr_next;
            key_wr_reg      <= key_wr_next;
            count_reg       <= count_next;
            issue_reg       <= issue_next;
            cmp_vld_reg     <= cmp_vld_next;
            hit_reg         <= hit_next;
            free_reg        <= free_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        serial_reg     <= serial_next;
        factory_reg    <= factory_next;
        index_reg      <= index_next;
        counter_reg    <= counter_next;
        key_reg        <= key_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        status_reg     <= status_next;
        eidx_reg       <= eidx_next;
        rd_serial_reg  <= rd_serial_next;
        rd_counter_reg <= rd_counter_next;
        rd_key_reg     <= rd_key_next;
        rd_valid_reg   <= rd_valid_next;
        rd_factory_reg <= rd_factory_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_index = eidx_reg;
    assign m_rd_serial   = rd_serial_reg;
    assign m_rd_counter  = rd_counter_reg;
    assign m_rd_key      = rd_key_reg;
    assign m_rd_valid    = rd_valid_reg;
    assign m_rd_factory  = rd_factory_reg;
    assign m_occupancy   = kpt_pkg::OCC_W'(count_reg);

    `KPT_ASSERT_NOW(a_count_matches, 1'b1, count_reg == CNT_W'($countones(valid_reg)), "occupancy count out of step with valid marks")
    `KPT_ASSERT_NOW(a_factory_needs_valid, 1'b1, (factory_vec_reg & ~valid_reg) == '0, "factory mark on an invalid entry")
    `KPT_ASSERT_NEXT(a_exec_gives_result, exec_go, m_valid_reg && (state_reg == S_IDLE), "finished item did not post a result")
    `KPT_ASSERT_NOW(a_no_scan_in_idle, state_reg == S_IDLE, !cmp_vld_reg, "compare active outside a scan")

endmodule
